// File: sv/rapq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rapq_pkg
// Shared types and constants for the range-add / point-query table.
// ----------------------------------------------------------------------------
package rapq_pkg;

    localparam int unsigned DEPTH  = 1024;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned CMP_W  = IDX_W + 1;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_QUERY
    } t_state;

endpackage : rapq_pkg
`default_nettype wire

// File: sv/rapq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rapq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rapq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : rapq_ram
`default_nettype wire

// File: sv/range_add_point_query_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_add_point_query_table
// Table of signed 32-bit entries with single-entry write, range add and
// point query, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A write is done in
// the cycle it is taken and leaves busy low. A query reads the RAM, then
// registers the entry; its result appears on o_entry_value with o_valid high
// for exactly one cycle, as busy falls again, and cannot be held off. A range
// add walks each entry from first to last with one read-modify-write per
// cycle on the single RAM, pipelined over its read and write ports. After
// reset the block clears the RAM with busy high before taking any request.
// ----------------------------------------------------------------------------
module range_add_point_query_table (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [rapq_pkg::OP_W-1:0]    i_operation,
    input  wire logic        [rapq_pkg::IDX_W-1:0]   i_first_index,
    input  wire logic        [rapq_pkg::IDX_W-1:0]   i_last_index,
    input  wire logic signed [rapq_pkg::DATA_W-1:0]  i_value,
    output logic                                     o_valid,
    output logic signed      [rapq_pkg::DATA_W-1:0]  o_entry_value
);

    localparam logic [rapq_pkg::ADDR_W-1:0] ADDR_MAX =
        rapq_pkg::ADDR_W'(rapq_pkg::DEPTH - 1);
    localparam logic [rapq_pkg::CMP_W-1:0] DEPTH_C =
        rapq_pkg::CMP_W'(rapq_pkg::DEPTH);

    rapq_pkg::t_state r_state, n_state;
    logic [rapq_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [rapq_pkg::ADDR_W-1:0] r_last, n_last;
    logic [rapq_pkg::DATA_W-1:0] r_delta, n_delta;
    logic                        r_oor, n_oor;
    logic                        r_valid, n_valid;
    logic [rapq_pkg::DATA_W-1:0] r_out, n_out;

    logic                        mem_we;
    logic [rapq_pkg::ADDR_W-1:0] mem_waddr;
    logic [rapq_pkg::DATA_W-1:0] mem_wdata;
    logic [rapq_pkg::ADDR_W-1:0] mem_raddr;
    logic [rapq_pkg::DATA_W-1:0] mem_rdata;

    logic accept;
    logic first_ok;
    logic last_ok;
    logic range_ok;
    logic last_done;
    logic [rapq_pkg::ADDR_W-1:0] first_addr;
    logic [rapq_pkg::ADDR_W-1:0] last_clip;

    assign busy       = (r_state != rapq_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign first_ok   = ({1'b0, i_first_index} < DEPTH_C);
    assign last_ok    = ({1'b0, i_last_index} < DEPTH_C);
    assign range_ok   = first_ok && (i_first_index <= i_last_index);
    assign first_addr = i_first_index[rapq_pkg::ADDR_W-1:0];
    assign last_clip  = last_ok ? i_last_index[rapq_pkg::ADDR_W-1:0] : ADDR_MAX;
    assign last_done  = (r_addr == r_last);

    rapq_ram #(
        .WIDTH (rapq_pkg::DATA_W),
        .DEPTH (rapq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            rapq_pkg::S_CLEAR: begin
                if (r_addr == ADDR_MAX) begin
                    n_state = rapq_pkg::S_IDLE;
                end
            end
            rapq_pkg::S_IDLE: begin
                if (accept) begin
                    case (rapq_pkg::t_op'(i_operation))
                        rapq_pkg::OP_ADD: begin
                            if (range_ok) begin
                                n_state = rapq_pkg::S_ADD;
                            end
                        end
                        rapq_pkg::OP_QUERY: n_state = rapq_pkg::S_QUERY;
                        default:            n_state = rapq_pkg::S_IDLE;
                    endcase
                end
            end
            rapq_pkg::S_ADD: begin
                if (last_done) begin
                    n_state = rapq_pkg::S_IDLE;
                end
            end
            rapq_pkg::S_QUERY: n_state = rapq_pkg::S_IDLE;
            default:           n_state = rapq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_addr    = r_addr;
        n_last    = r_last;
        n_delta   = r_delta;
        n_oor     = r_oor;
        n_valid   = 1'b0;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        mem_raddr = first_addr;
        case (r_state)
            rapq_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            rapq_pkg::S_IDLE: begin
                n_addr  = first_addr;
                n_last  = last_clip;
                n_delta = i_value;
                n_oor   = !first_ok;
                if (accept && (rapq_pkg::t_op'(i_operation) == rapq_pkg::OP_WRITE)) begin
                    mem_we    = first_ok;
                    mem_waddr = first_addr;
                    mem_wdata = i_value;
                end
            end
            rapq_pkg::S_ADD: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata + r_delta;
                mem_raddr = r_addr + 1'b1;
                n_addr    = r_addr + 1'b1;
            end
            rapq_pkg::S_QUERY: begin
                n_valid = 1'b1;
                n_out   = r_oor ? '0 : mem_rdata;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rapq_pkg::S_CLEAR;
            r_addr  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_delta <= n_delta;
        r_oor   <= n_oor;
        r_out   <= n_out;
    end

    assign o_valid       = r_valid;
    assign o_entry_value = r_out;

    a_valid_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == rapq_pkg::S_QUERY))
        else $error("result strobe without a preceding query");

    a_add_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rapq_pkg::S_ADD) |-> (r_addr <= r_last))
        else $error("range add walked past its last entry");

    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rapq_pkg::S_QUERY) |-> !mem_we)
        else $error("RAM write during a query");

    a_clear_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rapq_pkg::S_CLEAR && r_addr != ADDR_MAX)
            |=> (r_state == rapq_pkg::S_CLEAR))
        else $error("clearing pass ended early");

endmodule : range_add_point_query_table
`default_nettype wire
